// File: hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by the cell, the controller and the top level; depends on nothing.
`default_nettype none

package ffha_pkg;

  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned HDR_BYTES   = 17;
  localparam int unsigned SPLIT_SLACK = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_OOM    = 2'd2;
  localparam logic [1:0] ST_BADPTR = 2'd3;

  typedef struct packed {
    logic        valid;
    logic        free;
    logic [15:0] start;
    logic [16:0] bytes;
  } entry_t;

  typedef enum logic [1:0] {
    SW_ALLOC,
    SW_FREE,
    SW_MERGE
  } sweep_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SPLIT,
    ACT_WHOLE,
    ACT_MARK_FREE,
    ACT_MERGE
  } act_t;

  typedef struct packed {
    sweep_t      kind;
    logic        start;
    act_t        act;
    logic [15:0] size;
    logic [15:0] offset;
  } cmd_t;

  // Search token that walks the row one cell per cycle.
  typedef struct packed {
    logic        reach;
    logic        found;
    logic        split;
    logic [15:0] offset;
  } chain_t;

endpackage

`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator: a row of MAX_BLOCKS cells holds the block table in address order.
// A search token walks the row one cell per cycle; each sweep passes the token through every cell.
// Allocate: one search sweep; free: one sweep plus one merge sweep per coalesce and
// a final empty merge sweep; null free and zero-size allocate run no sweep.
// One item at a time. Synchronous reset leaves one free block spanning the whole arena.
// Depends on ffha_pkg, ffha_ctrl and ffha_cell.
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned ARENA_PAGES = 16,
  parameter int unsigned MAX_BLOCKS  = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_size [15:0], free_offset [31:16]
  input  logic [0:0]  s_tuser,   // op [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // payload_offset [15:0], status [17:16], zero [23:18]
);

  localparam logic [16:0] INIT_BYTES = 17'(ARENA_PAGES * PAGE_BYTES - HDR_BYTES);

  cmd_t   cmd;
  chain_t chain  [MAX_BLOCKS+1];
  entry_t ents   [MAX_BLOCKS+2];
  logic   wins   [MAX_BLOCKS+2];
  logic   full;

  // Boundary slots stand for the empty neighbors of the end cells.
  assign ents[0]            = '0;
  assign wins[0]            = 1'b0;
  assign ents[MAX_BLOCKS+1] = '0;
  assign wins[MAX_BLOCKS+1] = 1'b0;

  assign chain[0].reach  = cmd.start;
  assign chain[0].found  = 1'b0;
  assign chain[0].split  = 1'b0;
  assign chain[0].offset = 16'd0;

  assign full = ents[MAX_BLOCKS].valid;

  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .chain_exit (chain[MAX_BLOCKS]),
    .full       (full),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffha_cell #(
      .FIRST      ((i == 0) ? 1'b1 : 1'b0),
      .INIT_BYTES (INIT_BYTES)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .left_ent  (ents[i]),
      .left_win  (wins[i]),
      .right_ent (ents[i+2]),
      .right_win (wins[i+2]),
      .ent       (ents[i+1]),
      .win       (wins[i+1])
    );
  end

endmodule

`default_nettype wire

// File: hw/rtl/ffha_cell.sv
// One block-table entry of the allocator row, with its share of the search chain.
// Depends on ffha_pkg.
`default_nettype none

module ffha_cell
  import ffha_pkg::*;
#(
  parameter logic        FIRST      = 1'b0,
  parameter logic [16:0] INIT_BYTES = 17'd65519
) (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  chain_t chain_in,
  output chain_t chain_out,
  input  entry_t left_ent,
  input  logic   left_win,
  input  entry_t right_ent,
  input  logic   right_win,
  output entry_t ent,
  output logic   win
);

  logic        past;
  logic [16:0] hdr_end;
  logic        cond;
  logic        split_here;
  entry_t      new_ent;
  logic [16:0] merged_bytes;

  always_comb begin
    hdr_end    = {1'b0, ent.start} + 17'(HDR_BYTES);
    split_here = {1'b0, ent.bytes} > ({2'b00, cmd.size} + 18'(HDR_BYTES + SPLIT_SLACK));
    case (cmd.kind)
      SW_ALLOC: cond = ent.valid && ent.free && (ent.bytes >= {1'b0, cmd.size});
      SW_FREE:  cond = ent.valid && (hdr_end == {1'b0, cmd.offset});
      SW_MERGE: cond = ent.valid && ent.free && left_ent.valid && left_ent.free;
      default:  cond = 1'b0;
    endcase
    new_ent.valid = 1'b1;
    new_ent.free  = 1'b1;
    new_ent.start = left_ent.start + 16'(HDR_BYTES) + cmd.size;
    new_ent.bytes = left_ent.bytes - {1'b0, cmd.size} - 17'(HDR_BYTES);
    merged_bytes  = ent.bytes + 17'(HDR_BYTES) + right_ent.bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid       <= FIRST;
      ent.free        <= FIRST;
      ent.start       <= 16'd0;
      ent.bytes       <= INIT_BYTES;
      win             <= 1'b0;
      past            <= 1'b0;
      chain_out.reach <= 1'b0;
      chain_out.found <= 1'b0;
      chain_out.split <= 1'b0;
      chain_out.offset <= 16'd0;
    end else begin
      chain_out.reach <= chain_in.reach;
      if (chain_in.reach) begin
        win             <= cond && !chain_in.found;
        past            <= chain_in.found;
        chain_out.found <= chain_in.found || cond;
        if (cond && !chain_in.found) begin
          chain_out.offset <= hdr_end[15:0];
          chain_out.split  <= split_here;
        end else begin
          chain_out.offset <= chain_in.offset;
          chain_out.split  <= chain_in.split;
        end
      end
      case (cmd.act)
        ACT_SPLIT: begin
          if (win) begin
            ent.bytes <= {1'b0, cmd.size};
            ent.free  <= 1'b0;
          end else if (left_win) begin
            ent <= new_ent;
          end else if (past) begin
            ent <= left_ent;
          end
        end
        ACT_WHOLE: begin
          if (win) ent.free <= 1'b0;
        end
        ACT_MARK_FREE: begin
          if (win) ent.free <= 1'b1;
        end
        ACT_MERGE: begin
          // The right cell of the pair drops out and everything above it moves down.
          if (win || past) begin
            ent <= right_ent;
          end else if (right_win) begin
            ent.bytes <= merged_bytes;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ffha_ctrl.sv
// Sequencer of the allocator: stream handshake, search sweeps, actions, result beat.
// Depends on ffha_pkg.
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  input  chain_t      chain_exit,
  input  logic        full,
  output cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_MERGE_GO,
    S_DONE
  } state_t;

  state_t      state;
  logic [15:0] res_offset;
  logic [1:0]  res_status;
  logic [15:0] in_size;
  logic [15:0] in_offset;

  assign s_tready  = (state == S_IDLE);
  assign in_size   = s_tdata[15:0];
  assign in_offset = s_tdata[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      m_tdata    <= 24'd0;
      cmd.kind   <= SW_ALLOC;
      cmd.start  <= 1'b0;
      cmd.act    <= ACT_NONE;
      cmd.size   <= 16'd0;
      cmd.offset <= 16'd0;
      res_offset <= 16'd0;
      res_status <= ST_OK;
    end else begin
      cmd.start <= 1'b0;
      cmd.act   <= ACT_NONE;
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd.size   <= in_size;
            cmd.offset <= in_offset;
            res_offset <= 16'd0;
            if (s_tuser[0] == OP_FREE) begin
              if (in_offset == 16'd0) begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end else begin
                cmd.kind  <= SW_FREE;
                cmd.start <= 1'b1;
                state     <= S_SWEEP;
              end
            end else if (in_size == 16'd0) begin
              res_status <= ST_ZERO;
              state      <= S_DONE;
            end else begin
              cmd.kind  <= SW_ALLOC;
              cmd.start <= 1'b1;
              state     <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (chain_exit.reach) begin
            case (cmd.kind)
              SW_ALLOC: begin
                if (chain_exit.found) begin
                  cmd.act    <= (chain_exit.split && !full) ? ACT_SPLIT : ACT_WHOLE;
                  res_offset <= chain_exit.offset;
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_OOM;
                end
                state <= S_DONE;
              end
              SW_FREE: begin
                if (chain_exit.found) begin
                  cmd.act <= ACT_MARK_FREE;
                  state   <= S_MERGE_GO;
                end else begin
                  res_status <= ST_BADPTR;
                  state      <= S_DONE;
                end
              end
              default: begin
                // Merge sweeps repeat until no adjacent free pair is left.
                if (chain_exit.found) begin
                  cmd.act <= ACT_MERGE;
                  state   <= S_MERGE_GO;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_DONE;
                end
              end
            endcase
          end
        end
        S_MERGE_GO: begin
          cmd.kind  <= SW_MERGE;
          cmd.start <= 1'b1;
          state     <= S_SWEEP;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {6'd0, res_status, res_offset};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
